// ===== src/bbf_pkg.sv =====
// Shared constants, types and operation codes for the bounded byte FIFO.
package bbf_pkg;

  // Storage geometry
  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = 11;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 8;
  localparam int OFF_W   = 10;
  localparam int CAP_W   = 11;
  localparam int COUNT_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // Operation codes carried on func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_END   = 2'd3
  } func_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the operation beat and execute it
    logic cfg_we;  // write the capacity register
  } bbf_cmd_t;

endpackage

// ===== src/bbf_ctrl.sv =====
// Controller state machine: operation handshake, result strobe, config gating.
module bbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_valid,
  output logic             busy,
  output logic             done,
  output logic             cfg_ready,
  output bbf_pkg::bbf_cmd_t cmd
);
  import bbf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state;

  // Issue commands while idle
  assign cmd.load   = start && !busy;
  assign cmd.cfg_we = cfg_valid && !busy;
  assign cfg_ready  = !busy;

  // Hold state and the registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RESP;
            busy  <= 1'b1;
            done  <= 1'b1;
          end
        end
        S_RESP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/bbf_dp.sv =====
// Datapath: byte store, pointers, occupancy, flags, counters and result registers.
module bbf_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bbf_pkg::bbf_cmd_t               cmd,
  input  logic [bbf_pkg::FUNC_W-1:0]      func,
  input  logic [bbf_pkg::DATA_W-1:0]      data_in,
  input  logic [bbf_pkg::OFF_W-1:0]       offset,
  input  logic [bbf_pkg::CAP_W-1:0]       cfg_data,
  output logic                            accepted,
  output logic [bbf_pkg::DATA_W-1:0]      data_out,
  output logic                            data_valid,
  output logic [bbf_pkg::OCC_W-1:0]       fill_level,
  output logic [bbf_pkg::OCC_W-1:0]       free_space,
  output logic                            ended,
  output logic                            at_eof,
  output logic [bbf_pkg::COUNT_W-1:0]     total_written,
  output logic [bbf_pkg::COUNT_W-1:0]     total_read
);
  import bbf_pkg::*;

  logic [DATA_W-1:0]  byte_store [DEPTH];
  logic [PTR_W-1:0]   head_ptr, tail_ptr;
  logic [PTR_W-1:0]   head_next, tail_next;
  logic [OCC_W-1:0]   occupancy, occupancy_next;
  logic               input_done, input_done_next;
  logic [COUNT_W-1:0] written_count, read_count;
  logic [CAP_W-1:0]   capacity;
  logic [DATA_W-1:0]  rd_data;
  logic               accepted_q, valid_q;
  logic [OCC_W-1:0]   free_q, free_next;

  logic [OCC_W-1:0]   cap_eff;
  logic [PTR_W:0]     peek_sum;
  logic [PTR_W-1:0]   rd_addr;
  logic               wr_ok, pop_ok, peek_ok;

  // Clamp the capacity register to the storage depth
  always_comb begin
    if (32'(capacity) > 32'(DEPTH)) cap_eff = OCC_W'(DEPTH);
    else                           cap_eff = OCC_W'(capacity);
  end

  // Decide the operation and its read address
  always_comb begin
    wr_ok   = 1'b0;
    pop_ok  = 1'b0;
    peek_ok = 1'b0;
    case (func)
      FUNC_WRITE: wr_ok   = !input_done && (occupancy < cap_eff);
      FUNC_POP:   pop_ok  = (occupancy != '0);
      FUNC_PEEK:  peek_ok = (OCC_W'(offset) < occupancy);
      default:    ;
    endcase
    peek_sum = {1'b0, head_ptr} + (PTR_W+1)'(offset);
    if (32'(peek_sum) >= 32'(DEPTH)) peek_sum = peek_sum - (PTR_W+1)'(DEPTH);
    if (func == FUNC_PEEK) rd_addr = peek_sum[PTR_W-1:0];
    else                   rd_addr = head_ptr;
  end

  // Advance pointers, occupancy and the ended flag
  always_comb begin
    head_next       = head_ptr;
    tail_next       = tail_ptr;
    occupancy_next  = occupancy;
    input_done_next = input_done || (func == FUNC_END);
    if (wr_ok) begin
      tail_next      = (32'(tail_ptr) + 1 >= DEPTH) ? '0 : tail_ptr + 1'b1;
      occupancy_next = occupancy + 1'b1;
    end
    if (pop_ok) begin
      head_next      = (32'(head_ptr) + 1 >= DEPTH) ? '0 : head_ptr + 1'b1;
      occupancy_next = occupancy - 1'b1;
    end
    free_next = (occupancy_next < cap_eff) ? cap_eff - occupancy_next : '0;
  end

  // Write and read the byte store
  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) byte_store[tail_ptr] <= data_in;
    if (cmd.load)          rd_data <= byte_store[rd_addr];
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr      <= '0;
      tail_ptr      <= '0;
      occupancy     <= '0;
      input_done    <= 1'b0;
      written_count <= '0;
      read_count    <= '0;
      capacity      <= CAP_RESET;
    end else begin
      if (cmd.cfg_we) capacity <= cfg_data;
      if (cmd.load) begin
        head_ptr   <= head_next;
        tail_ptr   <= tail_next;
        occupancy  <= occupancy_next;
        input_done <= input_done_next;
        if (wr_ok)  written_count <= written_count + 1'b1;
        if (pop_ok) read_count    <= read_count + 1'b1;
      end
    end
  end

  // Capture result flags of the beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accepted_q <= wr_ok || pop_ok;
      valid_q    <= pop_ok || peek_ok;
      free_q     <= free_next;
    end
  end

  // Drive the result ports from registered state
  assign accepted      = accepted_q;
  assign data_valid    = valid_q;
  assign data_out      = valid_q ? rd_data : '0;
  assign fill_level    = occupancy;
  assign free_space    = free_q;
  assign ended         = input_done;
  assign at_eof        = input_done && (occupancy == '0);
  assign total_written = written_count;
  assign total_read    = read_count;

endmodule

// ===== src/bounded_byte_fifo_with_eof.sv =====
// Top level of the bounded byte FIFO with end-of-input flag.
//
//  channel    handshake            payload
//  ---------  -------------------  ----------------------------------------------
//  operation  start / busy         func, data_in, offset
//  result     done (one cycle)     accepted, data_out, data_valid, fill_level,
//                                  free_space, ended, at_eof, total_written,
//                                  total_read
//  config     cfg_valid/cfg_ready  cfg_data (capacity)
//
// Each operation: the accept edge updates the pointers and issues the byte
// store read, and the registered read data is shown with done high in the
// following cycle. The controller holds busy through that result cycle, so a
// new operation is not accepted until that cycle ends.
// Synchronous reset clears pointers, occupancy, the ended flag and counters
// and sets capacity to 1024; the store itself is not cleared. Results cannot
// be stalled; busy is high only during the cycle that done is shown.
module bounded_byte_fifo_with_eof (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bbf_pkg::FUNC_W-1:0]   func,
  input  logic [bbf_pkg::DATA_W-1:0]   data_in,
  input  logic [bbf_pkg::OFF_W-1:0]    offset,
  output logic                         done,
  output logic                         accepted,
  output logic [bbf_pkg::DATA_W-1:0]   data_out,
  output logic                         data_valid,
  output logic [bbf_pkg::OCC_W-1:0]    fill_level,
  output logic [bbf_pkg::OCC_W-1:0]    free_space,
  output logic                         ended,
  output logic                         at_eof,
  output logic [bbf_pkg::COUNT_W-1:0]  total_written,
  output logic [bbf_pkg::COUNT_W-1:0]  total_read,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bbf_pkg::CAP_W-1:0]    cfg_data
);
  import bbf_pkg::*;

  bbf_cmd_t cmd;

  // Sequence the operation beats
  bbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Execute operations on the byte store
  bbf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .data_in       (data_in),
    .offset        (offset),
    .cfg_data      (cfg_data),
    .accepted      (accepted),
    .data_out      (data_out),
    .data_valid    (data_valid),
    .fill_level    (fill_level),
    .free_space    (free_space),
    .ended         (ended),
    .at_eof        (at_eof),
    .total_written (total_written),
    .total_read    (total_read)
  );

endmodule
